/* hdl/cia_timer_interrupt_keyboard_unit_macros.svh */
// assertion macros for the port checker
`ifndef CIA_TIMER_INTERRUPT_KEYBOARD_UNIT_MACROS_SVH
`define CIA_TIMER_INTERRUPT_KEYBOARD_UNIT_MACROS_SVH

// clocked assertion, switched off while reset is held
`define CIA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// clocked assertion that also holds through reset
`define CIA_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* hdl/cia_pkg.sv */
// shared types and constants of the timer, interrupt and keyboard unit
package cia_pkg;

  // item kinds
  localparam logic [1:0] KIND_WRITE = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_TICK  = 2'd2;
  localparam logic [1:0] KIND_KEY   = 2'd3;

  // register offsets
  localparam logic [3:0] ADDR_COLUMN = 4'h0;
  localparam logic [3:0] ADDR_KBD    = 4'h1;
  localparam logic [3:0] ADDR_TA_LO  = 4'h4;
  localparam logic [3:0] ADDR_TA_HI  = 4'h5;
  localparam logic [3:0] ADDR_TB_LO  = 4'h6;
  localparam logic [3:0] ADDR_TB_HI  = 4'h7;
  localparam logic [3:0] ADDR_ICR    = 4'hD;
  localparam logic [3:0] ADDR_CRA    = 4'hE;
  localparam logic [3:0] ADDR_CRB    = 4'hF;

  // limits and fixed values
  localparam int          MAX_TICK_CYCLES = 255;
  localparam int          KEY_ROW_COUNT   = 8;
  localparam logic [15:0] TIMER_RESET     = 16'hFFFF;
  localparam logic [7:0]  READ_UNMAPPED   = 8'hFF;
  localparam logic [7:0]  ROW_RESET       = 8'hFF;

  // control register bits
  localparam int CTL_START   = 0;
  localparam int CTL_ONESHOT = 3;
  localparam int CTL_LOAD    = 4;

  // bits that hold a timer still
  localparam logic [7:0] IDLE_BITS_A = 8'h20;
  localparam logic [7:0] IDLE_BITS_B = 8'h60;

  // interrupt register fields
  localparam int ICR_SET  = 7;
  localparam int MASK_W   = 5;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] reg_addr;
    logic [7:0] write_data;
    logic [7:0] tick_cycles;
    logic [5:0] key_index;
    logic       key_pressed;
  } cia_in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq_active;
  } cia_out_t;

  // strobes from the decoder to one timer
  typedef struct packed {
    logic       tick;
    logic       wr_lo;
    logic       wr_hi;
    logic       wr_ctl;
    logic [7:0] data;
    logic [7:0] cycles;
  } tmr_ctl_t;

  // strobes from the decoder to the key matrix
  typedef struct packed {
    logic       col_wr;
    logic       key_ev;
    logic [5:0] key_index;
    logic       pressed;
    logic [7:0] data;
  } kbd_ctl_t;

endpackage

/* hdl/cia_timer_interrupt_keyboard_unit.sv */
// top level: input register, decode, timers, key matrix, interrupt logic, result register
//
// Takes one item per cycle while the result side does not stall and returns one
// result beat per item. The item passes through the input register into the
// result register and leaves when the result side does not stall. All work for
// an item (timer count and reload, interrupt flags, key matrix update and the
// read mux) sits in one combinational step between the input register and
// the result register, so the rate is set by that single stage. A stall on
// the result side holds the result register and then the input register;
// the input side stalls only while both are full.
module cia_timer_interrupt_keyboard_unit import cia_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  cia_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output cia_out_t out_data
);

  cia_in_t     in_data_r;
  logic        in_valid_r;
  cia_out_t    out_data_r, out_data_nxt;
  logic        out_valid_r;
  logic        advance;

  logic [7:0]  flags_r, flags_nxt;
  logic [MASK_W-1:0] mask_r, mask_nxt, mask_wr;
  logic        irq_r, irq_nxt;
  logic [7:0]  rd_data;

  logic        do_wr, do_rd, do_tick, do_key;
  logic [7:0]  cyc_sat;
  tmr_ctl_t    tmr_a_ctl, tmr_b_ctl;
  kbd_ctl_t    kbd_ctl;
  logic [15:0] count_a, count_b;
  logic        uf_a, uf_b;
  logic [1:0]  uf;
  logic [7:0]  kbd_scan;

  // handshake between the two registers
  assign advance   = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = in_valid_r && !advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_data_r <= in_data;
    end
  end

  // item decode
  assign do_wr   = advance && (in_data_r.kind == KIND_WRITE);
  assign do_rd   = advance && (in_data_r.kind == KIND_READ);
  assign do_tick = advance && (in_data_r.kind == KIND_TICK);
  assign do_key  = advance && (in_data_r.kind == KIND_KEY);

  // clamp the elapsed cycles
  assign cyc_sat = (32'(in_data_r.tick_cycles) > MAX_TICK_CYCLES) ?
                   8'(MAX_TICK_CYCLES) : in_data_r.tick_cycles;

  always_comb begin
    tmr_a_ctl.tick   = do_tick;
    tmr_a_ctl.wr_lo  = do_wr && (in_data_r.reg_addr == ADDR_TA_LO);
    tmr_a_ctl.wr_hi  = do_wr && (in_data_r.reg_addr == ADDR_TA_HI);
    tmr_a_ctl.wr_ctl = do_wr && (in_data_r.reg_addr == ADDR_CRA);
    tmr_a_ctl.data   = in_data_r.write_data;
    tmr_a_ctl.cycles = cyc_sat;
    tmr_b_ctl.tick   = do_tick;
    tmr_b_ctl.wr_lo  = do_wr && (in_data_r.reg_addr == ADDR_TB_LO);
    tmr_b_ctl.wr_hi  = do_wr && (in_data_r.reg_addr == ADDR_TB_HI);
    tmr_b_ctl.wr_ctl = do_wr && (in_data_r.reg_addr == ADDR_CRB);
    tmr_b_ctl.data   = in_data_r.write_data;
    tmr_b_ctl.cycles = cyc_sat;
    kbd_ctl.col_wr    = do_wr && (in_data_r.reg_addr == ADDR_COLUMN);
    kbd_ctl.key_ev    = do_key;
    kbd_ctl.key_index = in_data_r.key_index;
    kbd_ctl.pressed   = in_data_r.key_pressed;
    kbd_ctl.data      = in_data_r.write_data;
  end

  cia_timer u_timer_a (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (tmr_a_ctl),
    .idle_bits (IDLE_BITS_A),
    .count     (count_a),
    .underflow (uf_a)
  );

  cia_timer u_timer_b (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (tmr_b_ctl),
    .idle_bits (IDLE_BITS_B),
    .count     (count_b),
    .underflow (uf_b)
  );

  cia_kbd u_kbd (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (kbd_ctl),
    .scan  (kbd_scan)
  );

  assign uf = {uf_b, uf_a};

  // new mask on an interrupt register write
  assign mask_wr = in_data_r.write_data[ICR_SET] ?
                   (mask_r | in_data_r.write_data[MASK_W-1:0]) :
                   (mask_r & ~in_data_r.write_data[MASK_W-1:0]);

  // interrupt flags, mask, line and read mux
  always_comb begin
    flags_nxt = flags_r;
    mask_nxt  = mask_r;
    irq_nxt   = irq_r;
    rd_data   = 8'd0;
    if (do_wr && (in_data_r.reg_addr == ADDR_ICR)) begin
      mask_nxt = mask_wr;
      if ((flags_r[MASK_W-1:0] & mask_wr) != '0) begin
        flags_nxt[ICR_SET] = 1'b1;
        irq_nxt            = 1'b1;
      end
    end
    if (do_tick) begin
      flags_nxt[1:0] = flags_r[1:0] | uf;
      if ((uf & mask_r[1:0]) != 2'd0) begin
        flags_nxt[ICR_SET] = 1'b1;
        irq_nxt            = 1'b1;
      end
    end
    if (do_rd) begin
      unique case (in_data_r.reg_addr)
        ADDR_KBD:   rd_data = kbd_scan;
        ADDR_TA_LO: rd_data = count_a[7:0];
        ADDR_TA_HI: rd_data = count_a[15:8];
        ADDR_TB_LO: rd_data = count_b[7:0];
        ADDR_TB_HI: rd_data = count_b[15:8];
        ADDR_ICR: begin
          rd_data = {|(flags_r[MASK_W-1:0] & mask_r), flags_r[6:0]};
          flags_nxt = 8'd0;
          irq_nxt   = 1'b0;
        end
        default:    rd_data = READ_UNMAPPED;
      endcase
    end
    out_data_nxt.read_data  = rd_data;
    out_data_nxt.irq_active = irq_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= 8'd0;
      mask_r  <= '0;
      irq_r   <= 1'b0;
    end else begin
      flags_r <= flags_nxt;
      mask_r  <= mask_nxt;
      irq_r   <= irq_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

/* hdl/cia_timer.sv */
// one 16-bit down-counting timer with latch and control register
module cia_timer import cia_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  tmr_ctl_t    ctl,
  input  logic [7:0]  idle_bits,
  output logic [15:0] count,
  output logic        underflow
);

  logic [15:0] latch_r, latch_nxt;
  logic [15:0] count_r, count_nxt;
  logic [7:0]  ctl_r, ctl_nxt;
  logic        running;
  logic [15:0] cyc16;

  assign cyc16   = {8'd0, ctl.cycles};
  assign running = ctl_r[CTL_START] && ((ctl_r & idle_bits) == 8'd0);

  // underflow when the elapsed cycles reach the count
  assign underflow = ctl.tick && running && !(cyc16 < count_r);
  assign count     = count_r;

  // next state for writes and ticks
  always_comb begin
    latch_nxt = latch_r;
    count_nxt = count_r;
    ctl_nxt   = ctl_r;
    if (ctl.wr_lo) begin
      latch_nxt[7:0] = ctl.data;
    end
    if (ctl.wr_hi) begin
      latch_nxt[15:8] = ctl.data;
      if (!ctl_r[CTL_START]) begin
        count_nxt = {ctl.data, latch_r[7:0]};
      end
    end
    if (ctl.wr_ctl) begin
      ctl_nxt           = ctl.data;
      ctl_nxt[CTL_LOAD] = 1'b0;
      if (ctl.data[CTL_LOAD]) begin
        count_nxt = latch_r;
      end
    end
    if (ctl.tick && running) begin
      if (!underflow) begin
        count_nxt = count_r - cyc16;
      end else if (ctl_r[CTL_ONESHOT]) begin
        ctl_nxt[CTL_START] = 1'b0;
        count_nxt          = latch_r;
      end else begin
        // reload less the overshoot past zero
        count_nxt = latch_r + count_r - cyc16;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latch_r <= TIMER_RESET;
      count_r <= TIMER_RESET;
      ctl_r   <= 8'd0;
    end else begin
      latch_r <= latch_nxt;
      count_r <= count_nxt;
      ctl_r   <= ctl_nxt;
    end
  end

endmodule

/* hdl/cia_kbd.sv */
// 8x8 key matrix with column select and row scan
module cia_kbd import cia_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  kbd_ctl_t   ctl,
  output logic [7:0] scan
);

  logic [7:0] rows_r [KEY_ROW_COUNT];
  logic [7:0] column_r;
  logic [2:0] row_sel;
  logic [2:0] bit_sel;

  assign row_sel = ctl.key_index[5:3];
  assign bit_sel = ctl.key_index[2:0];

  // and together the rows whose column bit is low
  always_comb begin
    scan = READ_UNMAPPED;
    for (int i = 0; i < KEY_ROW_COUNT; i++) begin
      if (!column_r[i]) begin
        scan = scan & rows_r[i];
      end
    end
  end

  // column select register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_r <= 8'd0;
    end else if (ctl.col_wr) begin
      column_r <= ctl.data;
    end
  end

  // key matrix, pressed keys read low
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < KEY_ROW_COUNT; i++) begin
        rows_r[i] <= ROW_RESET;
      end
    end else if (ctl.key_ev) begin
      rows_r[row_sel][bit_sel] <= !ctl.pressed;
    end
  end

endmodule

/* hdl/cia_chk.sv */
// port checker for the timer, interrupt and keyboard unit, with its bind
`include "cia_timer_interrupt_keyboard_unit_macros.svh"

module cia_chk import cia_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_stall,
  input cia_in_t  in_data,
  input logic     out_valid,
  input logic     out_stall,
  input cia_out_t out_data
);

  // a held result beat keeps its payload
  `CIA_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_data), "result beat changed while stalled")

  // reset empties the result register
  `CIA_ASSERT_RST(a_rst_empty, !rst_n |=> !out_valid, "result valid after reset")

  // input side stalls only behind a stalled result
  `CIA_ASSERT(a_stall_cause, in_stall |-> out_valid && out_stall, "input stalled without result stall")

  // a taken item reaches the result port if no result stall follows it
  `CIA_ASSERT(a_latency, in_valid && !in_stall ##1 !out_stall |=> out_valid, "accepted item did not produce a result")

endmodule

bind cia_timer_interrupt_keyboard_unit cia_chk u_cia_chk (.*);

/* dv/cia_checker.sv */
// bus watcher for the timer, interrupt and keyboard unit: predicts each reply and compares it
module cia_checker import cia_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_stall,
  input  cia_in_t  in_data,
  input  logic     out_valid,
  input  logic     out_stall,
  input  cia_out_t out_data,
  output int       mismatches,
  output int       outstanding,
  output int       replies_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TMR_A = 0;
  localparam int TMR_B = 1;
  localparam logic [7:0] FLAG_TA = 8'h01;
  localparam logic [7:0] FLAG_TB = 8'h02;

  // shadow copy of the unit's registers
  logic [15:0] tmr_latch [2];
  logic [15:0] tmr_count [2];
  logic [7:0]  tmr_ctl   [2];
  logic [MASK_W-1:0] irq_mask;
  logic [7:0]  irq_flags;
  logic [7:0]  col_sel;
  logic [7:0]  key_rows [KEY_ROW_COUNT];
  logic        irq_line;

  cia_out_t reply_q [$];
  cia_out_t want;
  cia_out_t got_pred;

  initial begin
    mismatches      = 0;
    outstanding     = 0;
    replies_checked = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch on reply %0d: %s", replies_checked, msg);
    mismatches++;
  endtask

  task automatic clear_shadow();
    for (int t = 0; t < 2; t++) begin
      tmr_latch[t] = TIMER_RESET;
      tmr_count[t] = TIMER_RESET;
      tmr_ctl[t]   = 8'h00;
    end
    irq_mask  = '0;
    irq_flags = 8'h00;
    col_sel   = 8'h00;
    for (int r = 0; r < KEY_ROW_COUNT; r++) key_rows[r] = ROW_RESET;
    irq_line  = 1'b0;
  endtask

  // one timer over the elapsed cycles of a tick beat
  task automatic count_down(input int t, input logic [7:0] hold, input logic [7:0] flag,
                            input logic [7:0] cyc);
    logic [15:0] over;
    over = 16'h0000;
    if (tmr_ctl[t][CTL_START] && (tmr_ctl[t] & hold) == 8'h00) begin
      if ({8'h00, cyc} < tmr_count[t]) begin
        tmr_count[t] = tmr_count[t] - {8'h00, cyc};
      end else begin
        over = {8'h00, cyc} - tmr_count[t];
        irq_flags = irq_flags | flag;
        if ((irq_mask & flag[MASK_W-1:0]) != '0) begin
          irq_flags[ICR_SET] = 1'b1;
          irq_line = 1'b1;
        end
        // one-shot stops and reloads, continuous carries the overshoot
        if (tmr_ctl[t][CTL_ONESHOT]) begin
          tmr_ctl[t][CTL_START] = 1'b0;
          tmr_count[t] = tmr_latch[t];
        end else begin
          tmr_count[t] = tmr_latch[t] - over;
        end
      end
    end
  endtask

  task automatic write_reg(input logic [3:0] addr, input logic [7:0] v);
    int t;
    t = (addr == ADDR_TA_LO || addr == ADDR_TA_HI || addr == ADDR_CRA) ? TMR_A : TMR_B;
    case (addr)
      ADDR_COLUMN: col_sel = v;
      ADDR_TA_LO, ADDR_TB_LO: tmr_latch[t][7:0] = v;
      ADDR_TA_HI, ADDR_TB_HI: begin
        tmr_latch[t][15:8] = v;
        if (!tmr_ctl[t][CTL_START]) tmr_count[t] = tmr_latch[t];
      end
      ADDR_ICR: begin
        if (v[ICR_SET]) irq_mask = irq_mask | v[MASK_W-1:0];
        else irq_mask = irq_mask & ~v[MASK_W-1:0];
        if ((irq_flags[MASK_W-1:0] & irq_mask) != '0) begin
          irq_flags[ICR_SET] = 1'b1;
          irq_line = 1'b1;
        end
      end
      ADDR_CRA, ADDR_CRB: begin
        tmr_ctl[t] = v;
        // force-load is a strobe, never stored
        if (v[CTL_LOAD]) begin
          tmr_count[t] = tmr_latch[t];
          tmr_ctl[t][CTL_LOAD] = 1'b0;
        end
      end
      default: ;
    endcase
  endtask

  task automatic read_reg(input logic [3:0] addr, output logic [7:0] rd);
    case (addr)
      ADDR_KBD: begin
        rd = 8'hFF;
        for (int r = 0; r < KEY_ROW_COUNT; r++)
          if (!col_sel[r]) rd = rd & key_rows[r];
      end
      ADDR_TA_LO: rd = tmr_count[TMR_A][7:0];
      ADDR_TA_HI: rd = tmr_count[TMR_A][15:8];
      ADDR_TB_LO: rd = tmr_count[TMR_B][7:0];
      ADDR_TB_HI: rd = tmr_count[TMR_B][15:8];
      ADDR_ICR: begin
        // flags read back, then cleared along with the line
        rd = {1'b0, irq_flags[6:0]};
        if ((irq_flags[MASK_W-1:0] & irq_mask) != '0) rd[ICR_SET] = 1'b1;
        irq_flags = 8'h00;
        irq_line = 1'b0;
      end
      default: rd = READ_UNMAPPED;
    endcase
  endtask

  // advance the shadow by one input beat and work out its reply
  task automatic cia_apply(input cia_in_t b, output cia_out_t r);
    logic [7:0] rd;
    rd = 8'h00;
    case (b.kind)
      KIND_WRITE: write_reg(b.reg_addr, b.write_data);
      KIND_READ:  read_reg(b.reg_addr, rd);
      KIND_TICK: begin
        // an 8-bit count never exceeds the tick ceiling
        count_down(TMR_A, IDLE_BITS_A, FLAG_TA, b.tick_cycles);
        count_down(TMR_B, IDLE_BITS_B, FLAG_TB, b.tick_cycles);
      end
      default: key_rows[b.key_index[5:3]][b.key_index[2:0]] = ~b.key_pressed;
    endcase
    r.read_data  = rd;
    r.irq_active = irq_line;
  endtask

  // compare the reply beat first, it belongs to an older input beat
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_shadow();
      reply_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (reply_q.size() == 0) begin
          report_mismatch("reply beat with nothing pending");
        end else begin
          want = reply_q.pop_front();
          if (out_data.read_data !== want.read_data)
            report_mismatch($sformatf("read_data %02h, predicted %02h",
                                      out_data.read_data, want.read_data));
          if (out_data.irq_active !== want.irq_active)
            report_mismatch($sformatf("irq_active %b, predicted %b",
                                      out_data.irq_active, want.irq_active));
          replies_checked++;
        end
      end
      if (in_valid && !in_stall) begin
        cia_apply(in_data, got_pred);
        reply_q.push_back(got_pred);
      end
    end
    outstanding <= reply_q.size();
  end

endmodule

/* dv/tb_top.sv */
// top of the unit's testbench: clock, reset, beat stimulus, back-pressure and verdict
module tb_top import cia_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int LATENCY_SLACK = 8;
  localparam int RANDOM_BEATS  = 400;
  localparam logic [3:0] ADDR_GAP = 4'h2;   // offset with no register behind it

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  cia_in_t  in_data;
  logic     out_valid;
  logic     out_stall = 1'b0;
  cia_out_t out_data;
  logic     quiet = 1'b0;

  int mismatches;
  int outstanding;
  int replies_checked;
  int cycle_count = 0;
  int n_write = 0;
  int n_read  = 0;
  int n_tick  = 0;
  int n_key   = 0;

  cia_timer_interrupt_keyboard_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  cia_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data),
    .mismatches      (mismatches),
    .outstanding     (outstanding),
    .replies_checked (replies_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // random back-pressure on the reply side
  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= !quiet && ($urandom_range(99) < 17);
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("cia_timer_interrupt_keyboard_unit test failed");
      $finish;
    end
  end

  function automatic cia_in_t mk(input logic [1:0] kind, input logic [3:0] addr,
                                 input logic [7:0] data, input logic [7:0] cyc,
                                 input logic [5:0] key, input logic pressed);
    cia_in_t b;
    b.kind        = kind;
    b.reg_addr    = addr;
    b.write_data  = data;
    b.tick_cycles = cyc;
    b.key_index   = key;
    b.key_pressed = pressed;
    return b;
  endfunction

  // mostly timer programming, ticks and flag reads, with some stray offsets
  function automatic cia_in_t random_beat();
    cia_in_t     b;
    logic [31:0] raw;
    int          roll;
    raw  = $urandom;
    b    = raw[$bits(cia_in_t)-1:0];
    roll = $urandom_range(99);
    if (roll < 30) begin
      b.kind = KIND_TICK;
      if ($urandom_range(15) == 0) b.tick_cycles = 8'h00;
    end else if (roll < 55) begin
      b.kind = KIND_READ;
      if ($urandom_range(99) < 85) begin
        case ($urandom_range(6))
          0: b.reg_addr = ADDR_KBD;
          1: b.reg_addr = ADDR_TA_LO;
          2: b.reg_addr = ADDR_TA_HI;
          3: b.reg_addr = ADDR_TB_LO;
          4: b.reg_addr = ADDR_TB_HI;
          default: b.reg_addr = ADDR_ICR;
        endcase
      end
    end else if (roll < 85) begin
      b.kind = KIND_WRITE;
      if ($urandom_range(99) < 90) begin
        case ($urandom_range(7))
          0: b.reg_addr = ADDR_COLUMN;
          1: b.reg_addr = ADDR_TA_LO;
          2: b.reg_addr = ADDR_TA_HI;
          3: b.reg_addr = ADDR_TB_LO;
          4: b.reg_addr = ADDR_TB_HI;
          5: b.reg_addr = ADDR_ICR;
          6: b.reg_addr = ADDR_CRA;
          default: b.reg_addr = ADDR_CRB;
        endcase
      end
      // small latches so that ticks reach underflow often
      case (b.reg_addr)
        ADDR_TA_HI, ADDR_TB_HI:
          if ($urandom_range(99) < 75) b.write_data = 8'($urandom_range(1));
        ADDR_CRA, ADDR_CRB:
          if ($urandom_range(99) < 75) begin
            b.write_data[6:5] = 2'b00;
            b.write_data[CTL_START] = ($urandom_range(4) != 0);
          end
        default: ;
      endcase
    end else begin
      b.kind = KIND_KEY;
    end
    return b;
  endfunction

  // present one beat, with an occasional gap first, and hold it until taken
  task automatic send_beat(input cia_in_t b);
    if (!quiet && $urandom_range(99) < 17) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 17);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    case (b.kind)
      KIND_WRITE: n_write++;
      KIND_READ:  n_read++;
      KIND_TICK:  n_tick++;
      default:    n_key++;
    endcase
  endtask

  // hold the input side until every reply is back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  initial begin
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset values, unmapped offsets and the key matrix
    send_beat(mk(KIND_READ,  ADDR_KBD,    8'h00, 8'h00, 6'd0,  1'b0));
    send_beat(mk(KIND_READ,  ADDR_TA_LO,  8'h00, 8'h00, 6'd0,  1'b0));
    send_beat(mk(KIND_READ,  ADDR_GAP,    8'h00, 8'h00, 6'd0,  1'b0));
    send_beat(mk(KIND_WRITE, ADDR_GAP,    8'hFF, 8'h00, 6'd0,  1'b0));
    send_beat(mk(KIND_KEY,   ADDR_KBD,    8'h00, 8'h00, 6'd0,  1'b1));
    send_beat(mk(KIND_KEY,   ADDR_KBD,    8'h00, 8'h00, 6'd63, 1'b1));
    send_beat(mk(KIND_WRITE, ADDR_COLUMN, 8'h7F, 8'h00, 6'd0,  1'b0));
    send_beat(mk(KIND_READ,  ADDR_KBD,    8'h00, 8'h00, 6'd0,  1'b0));
    send_beat(mk(KIND_KEY,   ADDR_KBD,    8'h00, 8'h00, 6'd63, 1'b0));
    // continuous timer A with its interrupt enabled, overshoot carried
    send_beat(mk(KIND_WRITE, ADDR_TA_LO,  8'h05, 8'h00, 6'd0,  1'b0));
    send_beat(mk(KIND_WRITE, ADDR_TA_HI,  8'h00, 8'h00, 6'd0,  1'b0));
    send_beat(mk(KIND_WRITE, ADDR_ICR,    8'h81, 8'h00, 6'd0,  1'b0));
    send_beat(mk(KIND_WRITE, ADDR_CRA,    8'h01, 8'h00, 6'd0,  1'b0));
    send_beat(mk(KIND_TICK,  ADDR_KBD,    8'h00, 8'h07, 6'd0,  1'b0));
    send_beat(mk(KIND_READ,  ADDR_ICR,    8'h00, 8'h00, 6'd0,  1'b0));
    // one-shot timer B at zero, then a zero-cycle tick
    send_beat(mk(KIND_WRITE, ADDR_TB_LO,  8'h00, 8'h00, 6'd0,  1'b0));
    send_beat(mk(KIND_WRITE, ADDR_TB_HI,  8'h00, 8'h00, 6'd0,  1'b0));
    send_beat(mk(KIND_WRITE, ADDR_CRB,    8'h19, 8'h00, 6'd0,  1'b0));
    send_beat(mk(KIND_TICK,  ADDR_KBD,    8'h00, 8'h00, 6'd0,  1'b0));
    send_beat(mk(KIND_READ,  ADDR_ICR,    8'h00, 8'h00, 6'd0,  1'b0));
    // hold bits keep both timers still through the longest tick
    send_beat(mk(KIND_WRITE, ADDR_CRA,    8'h21, 8'h00, 6'd0,  1'b0));
    send_beat(mk(KIND_WRITE, ADDR_CRB,    8'h41, 8'h00, 6'd0,  1'b0));
    send_beat(mk(KIND_TICK,  ADDR_KBD,    8'h00, 8'hFF, 6'd0,  1'b0));
    send_beat(mk(KIND_READ,  ADDR_TA_LO,  8'h00, 8'h00, 6'd0,  1'b0));
    send_beat(mk(KIND_WRITE, ADDR_ICR,    8'h1F, 8'h00, 6'd0,  1'b0));
    drain();

    // random traffic, a calm stretch in the middle and a drain every hundred beats
    for (int i = 0; i < RANDOM_BEATS; i++) begin
      if (i == 150) quiet <= 1'b1;
      if (i == 250) quiet <= 1'b0;
      if (i > 0 && i % 100 == 0) drain();
      send_beat(random_beat());
    end
    drain();
    repeat (LATENCY_SLACK) @(posedge clk);

    $display("covered %0d writes, %0d reads, %0d ticks and %0d key events",
             n_write, n_read, n_tick, n_key);
    $display("%0d reply beats compared, %0d mismatches", replies_checked, mismatches);
    if (mismatches == 0) begin
      $display("cia_timer_interrupt_keyboard_unit test passed");
    end else begin
      $display("cia_timer_interrupt_keyboard_unit test failed");
    end
    $finish;
  end

endmodule
